// File: rtl/plt_pkg.sv
// Shared types and constants for the piecewise-linear table lookup.
// Used by plt_cell, plt_divider and piecewise_linear_table_lookup.
package plt_pkg;

  localparam int VW = 32;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [2:0] ST_IN_RANGE  = 3'd0;
  localparam logic [2:0] ST_OUTSIDE   = 3'd1;
  localparam logic [2:0] ST_NONFINITE = 3'd2;
  localparam logic [2:0] ST_STORED    = 3'd3;
  localparam logic [2:0] ST_REJECTED  = 3'd4;

  localparam logic [1:0] REG_ROWS    = 2'd0;
  localparam logic [1:0] REG_FIRST   = 2'd1;
  localparam logic [1:0] REG_SECOND  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN,
    S_MUL,
    S_DIVGO,
    S_DIV,
    S_DONE
  } plt_state_t;

  // Token that walks the row chain, one cell per cycle.
  typedef struct packed {
    logic          valid;
    logic          mode;
    logic [5:0]    idx;
    logic          ok;
    logic [VW-1:0] bp;
    logic [VW-1:0] v1;
    logic [VW-1:0] v2;
    logic [VW-1:0] q;
    logic          nf;
    logic          lo;
    logic          hi;
    logic          found;
    logic [VW-1:0] x0;
    logic [VW-1:0] x1;
    logic [VW-1:0] a0;
    logic [VW-1:0] a1;
    logic [VW-1:0] b0;
    logic [VW-1:0] b1;
    logic [VW-1:0] pbp;
    logic [VW-1:0] pa;
    logic [VW-1:0] pb;
  } plt_token_t;

endpackage

// File: rtl/plt_cell.sv
// One table row: stores breakpoint and two quantities, and updates the
// passing token. Depends on plt_pkg.
module plt_cell import plt_pkg::*; #(
  parameter int CELL_INDEX = 0,
  parameter int CNT_W      = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [CNT_W-1:0] n,
  input  plt_token_t       tin,
  output plt_token_t       tout
);

  logic [VW-1:0] bp;
  logic [VW-1:0] va;
  logic [VW-1:0] vb;
  plt_token_t    t;
  plt_token_t    tq;
  logic          vq;
  logic          at_row;
  logic          last;
  logic          wr;

  // Token update for the row held here.
  always_comb begin
    t      = tin;
    at_row = (int'(tin.idx) == CELL_INDEX);
    last   = (CELL_INDEX == int'(n) - 1);
    wr     = 1'b0;
    if (tin.mode == MODE_LOAD) begin
      if (at_row) begin
        if (CELL_INDEX > 0 && !(tin.bp > tin.pbp)) begin
          t.ok = 1'b0;
        end
        wr = tin.valid && t.ok;
      end
    end else begin
      if (CELL_INDEX == 0 && tin.q < bp) begin
        t.lo = 1'b1;
      end
      if (CELL_INDEX > 0 && CELL_INDEX < int'(n) && !tin.found && bp > tin.q) begin
        t.found = 1'b1;
        t.x0    = tin.pbp;
        t.x1    = bp;
        t.a0    = tin.pa;
        t.a1    = va;
        t.b0    = tin.pb;
        t.b1    = vb;
      end
      if (last) begin
        if (tin.q > bp) begin
          t.hi = 1'b1;
        end
        if (!t.found) begin
          t.a1 = va;
          t.b1 = vb;
        end
      end
    end
    t.pbp = bp;
    t.pa  = va;
    t.pb  = vb;
  end

  // Row storage.
  always_ff @(posedge clk) begin
    if (wr) begin
      bp <= tin.bp;
      va <= tin.v1;
      vb <= tin.v2;
    end
  end

  // Hand the token to the next cell.
  always_ff @(posedge clk) begin
    tq <= t;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vq <= 1'b0;
    end else begin
      vq <= tin.valid;
    end
  end

  always_comb begin
    tout       = tq;
    tout.valid = vq;
  end

endmodule

// File: rtl/plt_divider.sv
// Restoring divider, one quotient bit per cycle; quotient must fit VW bits.
// Depends on plt_pkg.
module plt_divider import plt_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [2*VW-1:0] num,
  input  logic [VW-1:0]   den,
  output logic            done,
  output logic [VW-1:0]   quo
);

  localparam int CW = $clog2(VW + 1);

  logic [VW-1:0] rem;
  logic [VW-1:0] lo;
  logic [VW-1:0] dv;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [VW:0]   shifted;
  logic          fits;

  always_comb begin
    shifted = {rem, lo[VW-1]};
    fits    = (shifted >= {1'b0, dv});
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num[2*VW-1:VW];
      lo  <= num[VW-1:0];
      dv  <= den;
    end else if (busy) begin
      rem <= fits ? VW'(shifted - {1'b0, dv}) : shifted[VW-1:0];
      lo  <= {lo[VW-2:0], 1'b0};
      quo <= {quo[VW-2:0], fits};
    end
  end

  // Step control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CW'(VW - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(VW - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// File: rtl/piecewise_linear_table_lookup.sv
// Piecewise-linear interpolation table built as a chain of row cells.
// Depends on plt_pkg, plt_cell and plt_divider.
//
// Input words arrive on s_tvalid/s_tready/s_tdata with s_tuser as mode:
// a load word stores one row after checking it, a query word looks up a
// point. Each input word yields exactly one output word on m_tvalid,
// m_tready, m_tdata, with m_tuser carrying the status code.
// Registers are written on cfg_valid/cfg_ready with cfg_index and cfg_data.
// One word is processed at a time. The word walks all TABLE_ROWS cells,
// one cell per cycle. Loads and out-of-range or nonfinite queries then go
// to the completion state, which loads the result into the output register
// and returns to idle, where the next word is taken. Interpolating queries
// first pass through a multiply state, a divider start state and the
// divider steps before they reach the completion state.
// The output register holds a finished word while the receiver stalls,
// and the next input word is taken meanwhile; it then waits for the
// output register before it is delivered.
// Reset clears the control state and sets the registers to 2, 1, 1;
// table contents are undefined until loaded.
module piecewise_linear_table_lookup import plt_pkg::*; #(
  parameter int TABLE_ROWS = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // row_index, row_breakpoint, row_first_value, row_second_value,
  // query_point, query_not_finite, zero pad
  input  logic [135:0] s_tdata,
  input  logic [0:0]   s_tuser,   // mode
  output logic         m_tvalid,
  input  logic         m_tready,
  // point_echo, first_result, first_result_valid, second_result,
  // second_result_valid, zero pad
  output logic [103:0] m_tdata,
  output logic [2:0]   m_tuser,   // status
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [6:0]   cfg_data
);

  localparam int CNT_W = $clog2(TABLE_ROWS + 1);

  plt_state_t      state;
  plt_state_t      state_next;
  logic [6:0]      rows_in_use;
  logic            en1;
  logic            en2;
  logic [CNT_W-1:0] n;
  plt_token_t      chain [TABLE_ROWS+1];
  plt_token_t      inj;
  plt_token_t      tk;
  logic [TABLE_ROWS-1:0] cv;
  logic            in_acc;
  logic            mul_en;
  logic            div_go;
  logic            out_ld;
  logic            use_div;
  logic [VW-1:0]   f;
  logic [VW-1:0]   span;
  logic [VW-1:0]   maga;
  logic [VW-1:0]   magb;
  logic            dira;
  logic            dirb;
  logic [2*VW-1:0] proda;
  logic [2*VW-1:0] prodb;
  logic            done_a;
  logic            done_b;
  logic [VW-1:0]   qa;
  logic [VW-1:0]   qb;
  logic [VW-1:0]   sa;
  logic [VW-1:0]   sb;
  logic [2:0]      o_status;
  logic [VW-1:0]   o_echo;
  logic [VW-1:0]   o_r1;
  logic [VW-1:0]   o_r2;
  logic            o_v1;
  logic            o_v2;
  plt_token_t      e;

  assign cfg_ready = 1'b1;
  assign in_acc    = s_tvalid && s_tready;
  assign e         = chain[TABLE_ROWS];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= 7'd2;
      en1         <= 1'b1;
      en2         <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROWS:   rows_in_use <= cfg_data;
        REG_FIRST:  en1 <= cfg_data[0];
        REG_SECOND: en2 <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  // Row count clamped to at least two and at most the table size.
  always_comb begin
    if (rows_in_use < 7'd2) begin
      n = CNT_W'(2);
    end else if (int'(rows_in_use) > TABLE_ROWS) begin
      n = CNT_W'(TABLE_ROWS);
    end else begin
      n = CNT_W'(rows_in_use);
    end
  end

  // Token entering the chain.
  always_comb begin
    inj       = '0;
    inj.valid = in_acc;
    inj.mode  = s_tuser[0];
    inj.idx   = s_tdata[5:0];
    inj.bp    = s_tdata[37:6];
    inj.v1    = s_tdata[69:38];
    inj.v2    = s_tdata[101:70];
    inj.q     = s_tdata[133:102];
    inj.nf    = s_tdata[134];
    inj.ok    = (int'(s_tdata[5:0]) < TABLE_ROWS) &&
                !(en1 && s_tdata[69:38] == '0) && !(en2 && s_tdata[101:70] == '0);
  end

  assign chain[0] = inj;

  for (genvar k = 0; k < TABLE_ROWS; k++) begin : g_cell
    plt_cell #(.CELL_INDEX(k), .CNT_W(CNT_W)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .n    (n),
      .tin  (chain[k]),
      .tout (chain[k+1])
    );
    assign cv[k] = chain[k+1].valid;
  end

  // Capture the token leaving the chain, with differences for the blend.
  always_ff @(posedge clk) begin
    if (e.valid) begin
      tk   <= e;
      f    <= e.q - e.x0;
      span <= e.x1 - e.x0;
      dira <= (e.a1 >= e.a0);
      dirb <= (e.b1 >= e.b0);
      maga <= (e.a1 >= e.a0) ? e.a1 - e.a0 : e.a0 - e.a1;
      magb <= (e.b1 >= e.b0) ? e.b1 - e.b0 : e.b0 - e.b1;
    end
  end

  // Products of magnitude and offset.
  always_ff @(posedge clk) begin
    if (mul_en) begin
      proda <= (2*VW)'(maga) * (2*VW)'(f);
      prodb <= (2*VW)'(magb) * (2*VW)'(f);
    end
  end

  plt_divider u_div_a (
    .clk   (clk),
    .rst   (rst),
    .start (div_go),
    .num   (proda + (2*VW)'(span >> 1)),
    .den   (span),
    .done  (done_a),
    .quo   (qa)
  );

  plt_divider u_div_b (
    .clk   (clk),
    .rst   (rst),
    .start (div_go),
    .num   (prodb + (2*VW)'(span >> 1)),
    .den   (span),
    .done  (done_b),
    .quo   (qb)
  );

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign use_div = (e.mode == MODE_QUERY) && !e.nf && !e.lo && !e.hi && e.found;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_acc) state_next = S_RUN;
      S_RUN:   if (e.valid) state_next = use_div ? S_MUL : S_DONE;
      S_MUL:   state_next = S_DIVGO;
      S_DIVGO: state_next = S_DIV;
      S_DIV:   if (done_a) state_next = S_DONE;
      S_DONE:  if (!m_tvalid || m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_tready = 1'b0;
    mul_en   = 1'b0;
    div_go   = 1'b0;
    out_ld   = 1'b0;
    case (state)
      S_IDLE:  s_tready = 1'b1;
      S_MUL:   mul_en = 1'b1;
      S_DIVGO: div_go = 1'b1;
      S_DONE:  out_ld = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  // Result word.
  always_comb begin
    sa       = (qa > maga) ? maga : qa;
    sb       = (qb > magb) ? magb : qb;
    o_r1     = '0;
    o_r2     = '0;
    o_v1     = 1'b0;
    o_v2     = 1'b0;
    o_status = ST_IN_RANGE;
    o_echo   = tk.q;
    if (tk.mode == MODE_LOAD) begin
      o_echo   = tk.bp;
      o_status = tk.ok ? ST_STORED : ST_REJECTED;
    end else if (tk.nf) begin
      o_status = ST_NONFINITE;
    end else if (tk.lo || tk.hi) begin
      o_status = ST_OUTSIDE;
    end else begin
      o_v1 = en1;
      o_v2 = en2;
      if (en1) begin
        o_r1 = !tk.found ? tk.a1 : (dira ? tk.a0 + sa : tk.a0 - sa);
      end
      if (en2) begin
        o_r2 = !tk.found ? tk.b1 : (dirb ? tk.b0 + sb : tk.b0 - sb);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (out_ld) begin
      m_tdata <= {6'd0, o_v2, o_r2, o_v1, o_r1, o_echo};
      m_tuser <= o_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ld) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // At most one word travels the chain.
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cv))
    else $error("more than one token in the row chain");

  // A token leaves the chain only while the sequencer waits for it.
  a_exit_in_run: assert property (@(posedge clk) disable iff (rst)
    e.valid |-> state == S_RUN)
    else $error("token left the chain outside the run state");

  // Both dividers start together and so finish together.
  a_div_pair: assert property (@(posedge clk) disable iff (rst)
    done_a == done_b)
    else $error("dividers out of step");

  // A finished word is presented on the next cycle.
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    out_ld |=> m_tvalid)
    else $error("result word not presented");

endmodule

// File: dv/plt_checker.sv
// Checker for the piecewise-linear table lookup: mirrors the register file and
// the row table, predicts each output word and compares it. Depends on plt_pkg.
`timescale 1ns / 100ps
module plt_checker import plt_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [135:0] s_tdata,
  input  logic [0:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [103:0] m_tdata,
  input  logic [2:0]   m_tuser,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [6:0]   cfg_data,
  output int           fail_count,
  output int           pending
);

  typedef struct packed {
    logic [2:0]    status;
    logic [VW-1:0] echo;
    logic [VW-1:0] first;
    logic          first_ok;
    logic [VW-1:0] second;
    logic          second_ok;
  } lookup_word_t;

  logic [VW-1:0] bp_mem [64];
  logic [VW-1:0] t_mem [64];
  logic [VW-1:0] l_mem [64];
  logic [6:0] rows_cfg;
  logic first_en, second_en;
  lookup_word_t expected_words[$];

  assign pending = expected_words.size();

  // Rounded linear blend between two row values, halves rounding up.
  function automatic logic [VW-1:0] blend_value(logic [VW-1:0] y0, logic [VW-1:0] y1,
                                                logic [63:0] frac, logic [63:0] span);
    logic [63:0] mag, stp;
    mag = (y1 >= y0) ? 64'(y1 - y0) : 64'(y0 - y1);
    stp = (mag * frac + span / 2) / span;
    if (stp > mag) stp = mag;
    return VW'((y1 >= y0) ? y0 + stp : y0 - stp);
  endfunction

  // Works out the output word for one input word and updates the table.
  function automatic lookup_word_t predict_lookup(logic md, logic [135:0] d);
    lookup_word_t w;
    logic [5:0] idx;
    logic [VW-1:0] bp, v1, v2, q;
    int n, hit;
    logic ok;
    idx = d[5:0];
    bp = d[37:6];
    v1 = d[69:38];
    v2 = d[101:70];
    q = d[133:102];
    w = '0;
    if (md == MODE_LOAD) begin
      w.echo = bp;
      ok = 1'b1;
      if (first_en && v1 == 0) ok = 1'b0;
      if (second_en && v2 == 0) ok = 1'b0;
      if (idx > 0 && !(bp > bp_mem[idx - 6'd1])) ok = 1'b0;
      if (ok) begin
        bp_mem[idx] = bp;
        t_mem[idx] = v1;
        l_mem[idx] = v2;
        w.status = ST_STORED;
      end else begin
        w.status = ST_REJECTED;
      end
      return w;
    end
    w.echo = q;
    if (d[134]) begin
      w.status = ST_NONFINITE;
      return w;
    end
    n = rows_cfg;
    if (n < 2) n = 2;
    if (n > 64) n = 64;
    if (q < bp_mem[0] || q > bp_mem[6'(n - 1)]) begin
      w.status = ST_OUTSIDE;
      return w;
    end
    w.status = ST_IN_RANGE;
    hit = 0;
    for (int k = 1; k < n; k++)
      if (hit == 0 && bp_mem[6'(k)] > q) hit = k;
    if (first_en) begin
      w.first_ok = 1'b1;
      w.first = (hit == 0) ? t_mem[6'(n - 1)] :
        blend_value(t_mem[6'(hit - 1)], t_mem[6'(hit)], q - bp_mem[6'(hit - 1)],
                    bp_mem[6'(hit)] - bp_mem[6'(hit - 1)]);
    end
    if (second_en) begin
      w.second_ok = 1'b1;
      w.second = (hit == 0) ? l_mem[6'(n - 1)] :
        blend_value(l_mem[6'(hit - 1)], l_mem[6'(hit)], q - bp_mem[6'(hit - 1)],
                    bp_mem[6'(hit)] - bp_mem[6'(hit - 1)]);
    end
    return w;
  endfunction

  // Watch all three channels at each rising edge.
  always @(posedge clk) begin
    lookup_word_t got, exp_w;
    if (rst) begin
      rows_cfg <= 7'd2;
      first_en <= 1'b1;
      second_en <= 1'b1;
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROWS:   rows_cfg <= cfg_data;
          REG_FIRST:  first_en <= cfg_data[0];
          REG_SECOND: second_en <= cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        expected_words = {expected_words, predict_lookup(s_tuser[0], s_tdata)};
      if (m_tvalid && m_tready) begin
        got.status = m_tuser;
        got.echo = m_tdata[31:0];
        got.first = m_tdata[63:32];
        got.first_ok = m_tdata[64];
        got.second = m_tdata[96:65];
        got.second_ok = m_tdata[97];
        if (expected_words.size() == 0) begin
          $error("output word with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          exp_w = expected_words.pop_front();
          if (got != exp_w) begin
            fail_count <= fail_count + 1;
            if (got.status != exp_w.status)
              $error("status exp %0d got %0d", exp_w.status, got.status);
            if (got.echo != exp_w.echo)
              $error("point_echo exp %h got %h", exp_w.echo, got.echo);
            if (got.first != exp_w.first)
              $error("first_result exp %h got %h", exp_w.first, got.first);
            if (got.first_ok != exp_w.first_ok)
              $error("first_result_valid exp %0d got %0d", exp_w.first_ok, got.first_ok);
            if (got.second != exp_w.second)
              $error("second_result exp %h got %h", exp_w.second, got.second);
            if (got.second_ok != exp_w.second_ok)
              $error("second_result_valid exp %0d got %0d", exp_w.second_ok, got.second_ok);
          end
        end
      end
    end
  end

endmodule

// File: dv/tb_top.sv
// Top of the table lookup testbench: clock, reset, stimulus and verdict.
// Depends on plt_pkg, plt_checker and piecewise_linear_table_lookup.
`timescale 1ns / 100ps
module tb_top;
  import plt_pkg::*;

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready, cfg_valid, cfg_ready;
  logic [135:0] s_tdata;
  logic [0:0] s_tuser;
  logic [103:0] m_tdata;
  logic [2:0] m_tuser;
  logic [1:0] cfg_index;
  logic [6:0] cfg_data;
  int fail_count, pending;
  int send_idle, recv_idle;
  int cycles;
  logic [VW-1:0] row_bp [64];

  piecewise_linear_table_lookup uut (.*);
  plt_checker chk (.*);

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 0; s_tdata = '0; s_tuser = '0; m_tready = 0;
    cfg_valid = 0; cfg_index = REG_ROWS; cfg_data = '0;
    send_idle = 0; recv_idle = 0;
  end

  // Timeout guard: slowest run is about 450 words with stalls.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end
  initial cycles = 0;

  // Receiver stalls at random.
  always @(posedge clk)
    m_tready <= ($urandom_range(99) >= recv_idle);

  task automatic write_reg(logic [1:0] idx, logic [6:0] val);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits for every expected word, then lets the block settle.
  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic send_word(logic md, logic [5:0] idx, logic [31:0] bp, logic [31:0] v1,
                           logic [31:0] v2, logic [31:0] q, logic nf);
    while ($urandom_range(99) < send_idle) @(posedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= md;
    s_tdata <= {1'b0, nf, q, v2, v1, bp, idx};
    do @(posedge clk); while (!s_tready);
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_row(int idx, logic [31:0] bp, logic [31:0] v1, logic [31:0] v2);
    send_word(MODE_LOAD, idx[5:0], bp, v1, v2, $urandom, 1'($urandom_range(1)));
  endtask

  task automatic query(logic [31:0] q, logic nf);
    send_word(MODE_QUERY, 6'($urandom), $urandom, $urandom, $urandom, q, nf);
  endtask

  // Loads rows 0..cnt-1 with increasing breakpoints and positive values.
  task automatic fill_table(int cnt, logic [31:0] start, int gap_max);
    logic [31:0] b;
    b = start;
    for (int r = 0; r < cnt; r++) begin
      row_bp[r] = b;
      load_row(r, b, ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : $urandom_range(1, 32'hFFFF_FFFE),
               ($urandom_range(3) == 0) ? 32'd1 : $urandom | 32'd1);
      b = b + $urandom_range(1, gap_max);
    end
  endtask

  task automatic random_query(int n);
    int r;
    r = $urandom_range(n - 2);
    case ($urandom_range(9))
      0: query($urandom, 1'b1);
      1: query($urandom, 1'b0);
      2: query(row_bp[n-1], 1'b0);
      3: query(row_bp[r], 1'b0);
      default: query(row_bp[r] + $urandom_range(row_bp[r+1] - row_bp[r]), 1'b0);
    endcase
  endtask

  initial begin
    int n;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, rejects, nonfinite, outside range, top clamp.
    load_row(0, 32'd0, 32'hFFFF_FFFF, 32'd1);
    load_row(1, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF);
    row_bp[0] = 0; row_bp[1] = 32'hFFFF_FFFF;
    load_row(1, 32'd0, 32'd5, 32'd5);          // breakpoint not above previous
    load_row(0, 32'd3, 32'd0, 32'd5);          // zero first quantity
    load_row(0, 32'd3, 32'd5, 32'd0);          // zero second quantity
    query(32'd0, 1'b0);
    query(32'hFFFF_FFFF, 1'b0);
    query(32'h8000_0000, 1'b0);
    query(32'h7FFF_FFFF, 1'b1);
    query(32'hFFFF_FFFF, 1'b1);
    drain();
    write_reg(REG_FIRST, 7'd0);
    write_reg(REG_SECOND, 7'd0);
    load_row(0, 32'd100, 32'd0, 32'd0);        // disabled quantities skip the check
    load_row(1, 32'd300, 32'd0, 32'd0);
    load_row(2, 32'd300, 32'd7, 32'd7);        // equal breakpoint rejected
    row_bp[0] = 100; row_bp[1] = 300;
    query(32'd99, 1'b0);
    query(32'd301, 1'b0);
    query(32'd200, 1'b0);
    drain();
    write_reg(REG_FIRST, 7'd1);
    write_reg(REG_ROWS, 7'd0);                 // below two acts as two
    query(32'd150, 1'b0);
    load_row(2, 32'hFFFF_FFFF, 32'd9, 32'd9);
    drain();
    write_reg(REG_SECOND, 7'd1);

    // Random phases across row counts, enables and idling profiles.
    for (int ph = 0; ph < 9; ph++) begin
      if (ph < 3) begin send_idle = 11; recv_idle = 70; end
      else if (ph < 6) begin send_idle = 70; recv_idle = 11; end
      else begin send_idle = 0; recv_idle = 0; end
      drain();
      case (ph % 3)
        0: n = (ph == 0) ? 64 : 127;
        1: n = 2;
        default: n = $urandom_range(3, 20);
      endcase
      write_reg(REG_ROWS, n[6:0]);
      write_reg(REG_FIRST, 7'($urandom_range(1)));
      write_reg(REG_SECOND, (ph % 3 == 0) ? 7'd1 : 7'($urandom_range(1)));
      if (n > 64) n = 64;
      fill_table(n, $urandom_range(1000), (n > 32) ? 32'h0100_0000 : 32'h0800_0000);
      for (int i = 0; i < 22; i++) begin
        if ($urandom_range(19) == 0)
          load_row($urandom_range(63), $urandom, $urandom_range(1), $urandom);
        else
          random_query(n);
      end
      // Rewrite a row with its own breakpoint, keeping the table consistent.
      if (ph == 7) begin
        drain();
        load_row(1, row_bp[1], 32'd44, 32'd55);
      end
    end

    drain();
    if (fail_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
